FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the queue block.
// Depends on nothing; the including scope provides clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fnp_pkg.sv
// Shared types and constants of the queue block with negative purge.
// Depends on nothing; used by every module of the block but the RAM.
package fnp_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_DUMP  = 2'd2,
    ACT_PURGE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_PURGE_RD,
    S_PURGE_CHK,
    S_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming request
    logic exec_single; // apply push or pop and record the request status
    logic walk_start;  // clear the walk counters
    logic rd_issue;    // read the entry under the walk counter
    logic walk_next;   // advance the walk counter
    logic purge_keep;  // write back the entry read if it is not negative
    logic purge_done;  // take the kept count as the new occupancy
    logic load_item;   // load a dump entry into the output register
    logic load_status; // load a single status result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    empty;
    logic    walk_last;
    logic    out_free;
  } stat_t;

endpackage

FILE: rtl/fnp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module fnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fnp_ctrl.sv
// Controller state machine of the queue block: sequences each request.
// Depends on fnp_pkg.
module fnp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  fnp_pkg::stat_t stat,
  output fnp_pkg::cmd_t  cmd
);
  import fnp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.action)
          ACT_DUMP:  state_next = stat.empty ? S_REPORT : S_DUMP_RD;
          ACT_PURGE: state_next = stat.empty ? S_REPORT : S_PURGE_RD;
          default:   state_next = S_REPORT;
        endcase
      end
      S_DUMP_RD: state_next = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (stat.out_free) state_next = stat.walk_last ? S_IDLE : S_DUMP_RD;
      end
      S_PURGE_RD:  state_next = S_PURGE_CHK;
      S_PURGE_CHK: state_next = stat.walk_last ? S_REPORT : S_PURGE_RD;
      S_REPORT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_DISPATCH: begin
        if ((stat.action == ACT_DUMP || stat.action == ACT_PURGE) && !stat.empty) begin
          cmd.walk_start = 1'b1;
        end else begin
          cmd.exec_single = 1'b1;
        end
      end
      S_DUMP_RD:  cmd.rd_issue = 1'b1;
      S_DUMP_OUT: begin
        cmd.load_item = stat.out_free;
        cmd.walk_next = stat.out_free && !stat.walk_last;
      end
      S_PURGE_RD: cmd.rd_issue = 1'b1;
      S_PURGE_CHK: begin
        cmd.purge_keep = 1'b1;
        cmd.walk_next  = !stat.walk_last;
        cmd.purge_done = stat.walk_last;
      end
      S_REPORT: cmd.load_status = stat.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/fnp_dpath.sv
// Datapath of the queue block: pointers, walk counters, entry RAM, output register.
// Depends on fnp_pkg and fnp_ram.
module fnp_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fnp_pkg::cmd_t                cmd,
  output fnp_pkg::stat_t               stat,
  input  logic [1:0]                   in_action,
  input  logic [fnp_pkg::WORD_W-1:0]   in_value,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [fnp_pkg::WORD_W-1:0]   out_item,
  output logic [fnp_pkg::LEN_W-1:0]    out_len,
  output logic                         out_last
);
  import fnp_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]  head;
  logic [OCC_W-1:0]  occ;
  logic [IDX_W-1:0]  walk_i;
  logic [OCC_W-1:0]  kept;
  action_t           action;
  logic [WORD_W-1:0] value;
  status_t           status;
  status_t           status_q;

  logic              empty;
  logic              full;
  logic              walk_last;
  logic              out_free;
  logic              keep_now;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [OCC_W+LEN_W-1:0] len_ext;

  // Position offset entries past base, wrapped modulo DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) sum = sum - (IDX_W + 1)'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  assign empty     = (occ == '0);
  assign full      = (occ == OCC_W'(DEPTH));
  assign walk_last = ((OCC_W'(walk_i) + OCC_W'(1)) == occ);
  assign out_free  = !out_valid || out_ready;
  assign keep_now  = cmd.purge_keep && !ram_rdata[WORD_W-1];

  always_comb begin
    stat.action    = action;
    stat.empty     = empty;
    stat.walk_last = walk_last;
    stat.out_free  = out_free;
  end

  always_comb begin
    if (action == ACT_PUSH && full)                status = ST_FULL;
    else if (action != ACT_PUSH && empty)          status = ST_EMPTY;
    else                                           status = ST_OK;
  end

  // One write port serves both push and purge compaction; they never overlap.
  always_comb begin
    if (cmd.purge_keep) begin
      ram_we    = keep_now;
      ram_waddr = wrap_add(head, kept[IDX_W-1:0]);
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd.exec_single && action == ACT_PUSH && !full;
      ram_waddr = wrap_add(head, occ[IDX_W-1:0]);
      ram_wdata = value;
    end
  end

  assign ram_raddr = wrap_add(head, walk_i);

  fnp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action <= action_t'(in_action);
      value  <= in_value;
    end
    if (cmd.exec_single) status_q <= status;
    if (cmd.walk_start)  status_q <= ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      occ    <= '0;
      walk_i <= '0;
      kept   <= '0;
    end else begin
      if (cmd.exec_single) begin
        if (action == ACT_PUSH && !full) begin
          occ <= occ + OCC_W'(1);
        end else if (action == ACT_POP && !empty) begin
          head <= wrap_add(head, IDX_W'(1));
          occ  <= occ - OCC_W'(1);
        end
      end
      if (cmd.walk_start) begin
        walk_i <= '0;
        kept   <= '0;
      end
      if (cmd.walk_next) walk_i <= walk_i + IDX_W'(1);
      if (keep_now)      kept   <= kept + OCC_W'(1);
      if (cmd.purge_done) occ   <= kept + OCC_W'(keep_now);
    end
  end

  assign len_ext = {{LEN_W{1'b0}}, occ};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_item || cmd.load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      out_status <= ST_OK;
      out_item   <= ram_rdata;
      out_len    <= len_ext[LEN_W-1:0];
      out_last   <= walk_last;
    end else if (cmd.load_status) begin
      out_status <= status_q;
      out_item   <= '0;
      out_len    <= len_ext[LEN_W-1:0];
      out_last   <= 1'b1;
    end
  end

endmodule

FILE: rtl/fifo_with_negative_purge_unit.sv
// Top level of the bounded word queue with in-place purge of negative entries.
// Depends on fnp_pkg, fnp_ctrl, fnp_dpath (and fnp_ram through the datapath).
//
//  channel | dir | tdata (low bit first)          | tuser      | tlast
//  --------+-----+--------------------------------+------------+-----------
//  s_*     | in  | value[31:0], 8'b0 pad          | action     | -
//  m_*     | out | item[31:0], length[37:32], pad | status     | last
//
// Push, pop, any empty-queue request: dispatch, report. Dump reads and outputs
// each entry; purge reads and checks each, then reports. The pace
// is set by the single read port of the entry RAM and its registered read data.
// Reset (rst, synchronous) empties the queue; entry contents are not cleared.
// A request is taken only between requests; a held result stalls the dump
// walk, and the next request is accepted while the final result still waits.
module fifo_with_negative_purge_unit #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [31:0] value, [39:32] zero pad
  input  logic [1:0]  s_tuser,  // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] item, [37:32] length, [39:38] zero pad
  output logic [1:0]  m_tuser,  // [1:0] status
  output logic        m_tlast
);
  import fnp_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [WORD_W-1:0] out_item;
  logic [LEN_W-1:0]  out_len;

  // Sequence each request: dispatch, then walk the entries, report, or both.
  fnp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the pointers, the entry store and the output register.
  fnp_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_value   (s_tdata[WORD_W-1:0]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_item   (out_item),
    .out_len    (out_len),
    .out_last   (m_tlast)
  );

  // Pack the result: item low, length above it, zero pad to whole bytes.
  assign m_tdata = {2'b00, out_len, out_item};

endmodule

FILE: rtl/fnp_checker.sv
// Port-level checker for the queue block, bound to the top level.
// Depends on fnp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fnp_checker #(
  parameter int DEPTH = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import fnp_pkg::*;

  // Reset drops any pending result.
  `ASSERT_RST(a_rst_clears_out, rst |=> !m_tvalid, "result valid after reset")

  // A non-ok result is the only result of its request and carries no item.
  `ASSERT_CHK(a_err_single, (m_tvalid && m_tuser != ST_OK) |-> (m_tlast && m_tdata[31:0] == '0), "error result not final or item not zero")

  // A dropped push leaves a full queue.
  `ASSERT_CHK(a_full_len, (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[37:32] == LEN_W'(DEPTH)), "full status with wrong length")

  // A stalled result holds.
  `ASSERT_CHK(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

endmodule

bind fifo_with_negative_purge_unit fnp_checker #(.DEPTH(DEPTH)) u_fnp_checker (.*);
